// ===== hdl/swpm_pkg.sv =====
// Shared types and constants for the sliding window percentile monitor.
package swpm_pkg;

    localparam int WINDOW     = 128;
    localparam int VAL_W      = 40;
    localparam int IDX_W      = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int FILL_W     = $clog2(WINDOW + 1);
    localparam int TOTAL_W    = 32;
    localparam int OUT_FILL_W = 8;
    localparam int S_DATA_W   = 40;
    localparam int M_DATA_W   = 200;

    // ceil(n/100) = floor((n+99)/100); floor(y/100) = (y*5243)>>19, exact for y < 43699
    localparam int CEIL_BIAS   = 99;
    localparam int RECIP_MUL   = 5243;
    localparam int RECIP_SHIFT = 19;

    typedef logic [VAL_W-1:0] val_t;

    // insertion token walking the cell row
    typedef struct packed {
        logic             valid;
        logic             done;
        logic             found;
        logic [IDX_W-1:0] remaining;
        val_t             carry;
        val_t             med;
        val_t             p99;
    } tok_t;

    // per-transaction command, held steady while the token walks
    typedef struct packed {
        logic             remove;
        val_t             old;
        logic [IDX_W-1:0] rm_med;
        logic [IDX_W-1:0] rm_p99;
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_WAVE,
        ST_DONE
    } state_t;

endpackage

// ===== hdl/swpm_ram.sv =====
// Generic single-port-write, registered-read RAM.
module swpm_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/swpm_cell.sv =====
// One sorted-window cell: holds one entry, merges the passing token.
module swpm_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  swpm_pkg::cmd_t cmd,
    input  swpm_pkg::val_t right_val,
    output swpm_pkg::val_t val,
    input  swpm_pkg::tok_t tok_in,
    output swpm_pkg::tok_t tok_out
);

    swpm_pkg::val_t val_reg;
    swpm_pkg::val_t val_next;
    swpm_pkg::tok_t tok_reg;
    swpm_pkg::tok_t tok_next;

    always_comb
    begin
        logic           match;
        logic           found_now;
        swpm_pkg::val_t eff;
        swpm_pkg::val_t wr;

        match     = cmd.remove && (val_reg == cmd.old);
        found_now = tok_in.found || match;
        // entry as seen after the removal shift
        eff       = found_now ? right_val : val_reg;
        wr        = val_reg;
        val_next  = val_reg;
        tok_next  = tok_in;

        if (tok_in.valid && !tok_in.done)
        begin
            if (tok_in.remaining == '0)
            begin
                // end of the new window: park the carried maximum here
                wr            = tok_in.carry;
                tok_next.done = 1'b1;
            end
            else
            begin
                if (eff < tok_in.carry)
                begin
                    wr             = eff;
                    tok_next.carry = tok_in.carry;
                end
                else
                begin
                    wr             = tok_in.carry;
                    tok_next.carry = eff;
                end
                tok_next.remaining = tok_in.remaining - 1'b1;
                tok_next.found     = found_now;
            end
            val_next = wr;
            if (tok_in.remaining == cmd.rm_med)
            begin
                tok_next.med = wr;
            end
            if (tok_in.remaining == cmd.rm_p99)
            begin
                tok_next.p99 = wr;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val     = val_reg;
    assign tok_out = tok_reg;

endmodule

// ===== hdl/sliding_window_percentile_monitor.sv =====
// Top level: sliding window median / p99 / max monitor over a cell row.
//
// Each sample accepted on the s_ stream yields one result on the m_ stream,
// taken over the newest WINDOW samples after the new one is added. The
// samples live twice: in arrival order in a ring RAM, and in ascending order
// in a row of WINDOW cells. A sample walks the cell row as a token, one cell
// per clock; in one pass it drops the oldest sample (when the window is full),
// inserts the new one, and picks up the median and p99 entries on the way.
// One sample is in flight at a time: between one acceptance and the next
// come the accept cycle with the ring read, the token load, the
// WINDOW-cell token walk and the result handoff.
// The handoff also waits while an earlier result is held on m_tvalid
// without m_tready. The finished result sits in an output register,
// so a new sample may be taken while it waits.
// The ring and the cell contents need no clearing: only entries below the
// fill count are ever used.
module sliding_window_percentile_monitor (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [swpm_pkg::S_DATA_W-1:0] s_tdata,  // [39:0] sample_value
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [39:0] newest_value, [79:40] median_value, [119:80] p99_value,
    // [159:120] max_value, [167:160] window_fill, [199:168] frames_seen
    output logic [swpm_pkg::M_DATA_W-1:0] m_tdata
);

    localparam int W = swpm_pkg::WINDOW;

    swpm_pkg::state_t state_reg;
    swpm_pkg::state_t state_next;

    // bookkeeping
    logic [swpm_pkg::FILL_W-1:0]  fill_reg;
    logic [swpm_pkg::IDX_W-1:0]   ring_reg;
    logic [swpm_pkg::TOTAL_W-1:0] total_reg;

    // per-transaction command
    swpm_pkg::val_t               sample_reg;
    logic                         remove_reg;
    logic [swpm_pkg::IDX_W-1:0]   rem_reg;
    logic [swpm_pkg::IDX_W-1:0]   rm_med_reg;
    logic [swpm_pkg::IDX_W-1:0]   rm_p99_reg;

    // result staging and output register
    swpm_pkg::val_t               res_med_reg;
    swpm_pkg::val_t               res_p99_reg;
    swpm_pkg::val_t               res_max_reg;
    logic                         m_tvalid_reg;
    logic [swpm_pkg::M_DATA_W-1:0] m_tdata_reg;

    // FSM outputs
    logic accept;
    logic inject;
    logic capture;
    logic out_load;

    // accept-time arithmetic
    logic                         full;
    logic [swpm_pkg::IDX_W-1:0]   slot_calc;
    logic [swpm_pkg::FILL_W-1:0]  n_new;
    logic [swpm_pkg::FILL_W-1:0]  m_new;
    logic [31:0]                  ceil_num;
    logic [31:0]                  ceil_q;

    // cell row
    swpm_pkg::cmd_t               cmd;
    swpm_pkg::tok_t               tok_chain [W+1];
    swpm_pkg::val_t               cell_val  [W];
    logic [W:0]                   tok_valid_vec;
    swpm_pkg::val_t               ring_rdata;

    //------------------------------------------------------------------
    // Next-state logic
    //------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            swpm_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = swpm_pkg::ST_LOAD;
                end
            end
            swpm_pkg::ST_LOAD:
            begin
                state_next = swpm_pkg::ST_WAVE;
            end
            swpm_pkg::ST_WAVE:
            begin
                if (tok_chain[W].valid)
                begin
                    state_next = swpm_pkg::ST_DONE;
                end
            end
            swpm_pkg::ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    state_next = swpm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = swpm_pkg::ST_IDLE;
            end
        endcase
    end

    //------------------------------------------------------------------
    // FSM outputs
    //------------------------------------------------------------------
    always_comb
    begin
        s_tready = 1'b0;
        inject   = 1'b0;
        capture  = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            swpm_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
            end
            swpm_pkg::ST_LOAD:
            begin
                inject = 1'b1;
            end
            swpm_pkg::ST_WAVE:
            begin
                capture = tok_chain[W].valid;
            end
            swpm_pkg::ST_DONE:
            begin
                out_load = !m_tvalid_reg || m_tready;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    assign accept = s_tvalid && s_tready;

    //------------------------------------------------------------------
    // Accept-time arithmetic: new slot, new count, pick positions
    //------------------------------------------------------------------
    always_comb
    begin
        full = (fill_reg == swpm_pkg::FILL_W'(W));
        if (fill_reg == '0)
        begin
            slot_calc = '0;
        end
        else if (ring_reg == swpm_pkg::IDX_W'(W - 1))
        begin
            slot_calc = '0;
        end
        else
        begin
            slot_calc = ring_reg + 1'b1;
        end
        n_new    = full ? fill_reg : fill_reg + 1'b1;
        m_new    = n_new - 1'b1;
        // p99 index = n - ceil(n/100); its distance from the top is ceil - 1
        ceil_num = 32'(n_new) + 32'(swpm_pkg::CEIL_BIAS);
        ceil_q   = (ceil_num * 32'(swpm_pkg::RECIP_MUL)) >> swpm_pkg::RECIP_SHIFT;
    end

    //------------------------------------------------------------------
    // Control registers
    //------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= swpm_pkg::ST_IDLE;
            fill_reg     <= '0;
            ring_reg     <= '0;
            total_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                fill_reg  <= n_new;
                ring_reg  <= slot_calc;
                total_reg <= total_reg + 1'b1;
            end
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    //------------------------------------------------------------------
    // Payload registers
    //------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg <= s_tdata[swpm_pkg::VAL_W-1:0];
            remove_reg <= full;
            rem_reg    <= swpm_pkg::IDX_W'(m_new);
            rm_med_reg <= swpm_pkg::IDX_W'(m_new - (n_new >> 1));
            rm_p99_reg <= swpm_pkg::IDX_W'(ceil_q - 32'd1);
        end
        if (capture)
        begin
            res_med_reg <= tok_chain[W].med;
            res_p99_reg <= tok_chain[W].p99;
            res_max_reg <= tok_chain[W].carry;
        end
        if (out_load)
        begin
            m_tdata_reg <= {total_reg,
                            swpm_pkg::OUT_FILL_W'(fill_reg),
                            res_max_reg,
                            res_p99_reg,
                            res_med_reg,
                            sample_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    //------------------------------------------------------------------
    // Arrival ring: read the oldest slot at accept, write the new sample
    // into it in the next cycle.
    //------------------------------------------------------------------
    swpm_ram #(
        .WIDTH (swpm_pkg::VAL_W),
        .DEPTH (W)
    ) u_ring (
        .clk     (clk),
        .wr_en   (inject),
        .wr_addr (ring_reg),
        .wr_data (sample_reg),
        .rd_en   (accept),
        .rd_addr (slot_calc),
        .rd_data (ring_rdata)
    );

    //------------------------------------------------------------------
    // Sorted cell row; the token enters cell 0 in the load state.
    //------------------------------------------------------------------
    assign cmd = '{remove: remove_reg,
                   old:    ring_rdata,
                   rm_med: rm_med_reg,
                   rm_p99: rm_p99_reg};

    assign tok_chain[0] = '{valid:     inject,
                            done:      1'b0,
                            found:     1'b0,
                            remaining: rem_reg,
                            carry:     sample_reg,
                            med:       '0,
                            p99:       '0};

    for (genvar i = 0; i < W; i++)
    begin : g_cell
        swpm_pkg::val_t right_val;

        if (i == W - 1)
        begin : g_last
            assign right_val = '0;
        end
        else
        begin : g_mid
            assign right_val = cell_val[i+1];
        end

        swpm_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmd       (cmd),
            .right_val (right_val),
            .val       (cell_val[i]),
            .tok_in    (tok_chain[i]),
            .tok_out   (tok_chain[i+1])
        );
    end

    for (genvar k = 0; k <= W; k++)
    begin : g_tokv
        assign tok_valid_vec[k] = tok_chain[k].valid;
    end

    //------------------------------------------------------------------
    // Assertions
    //------------------------------------------------------------------
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= swpm_pkg::FILL_W'(W))
        else $error("fill count above window size");

    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(tok_valid_vec) <= 1)
        else $error("more than one token in the cell row");

    a_exit_in_wave: assert property (@(posedge clk) disable iff (!rst_n)
        tok_chain[W].valid |-> state_reg == swpm_pkg::ST_WAVE)
        else $error("token left the row outside the wave state");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == swpm_pkg::ST_DONE))
        else $error("result raised without a finished transaction");

endmodule

// ===== dv/sliding_window_percentile_monitor_test.sv =====
// Self-checking testbench for the sliding window percentile monitor.
`timescale 1ns / 1ps

module sliding_window_percentile_monitor_test;

    import swpm_pkg::*;

    localparam int   RANDOM_ITEMS = 2000;
    localparam int   PHASE_ITEMS  = 250;   // items per idling phase
    localparam int   DRAIN_EVERY  = 400;   // random items between full drains
    localparam int   QUIET_LIMIT  = 20000; // cycles with no transaction at all
    localparam int   LONG_HOLD    = WINDOW + 40;
    localparam val_t VAL_MAX      = {VAL_W{1'b1}};

    // Result fields as packed on m_tdata, first field in the highest bits.
    typedef struct packed {
        logic [TOTAL_W-1:0]    frames;
        logic [OUT_FILL_W-1:0] fill;
        val_t                  maximum;
        val_t                  p99;
        val_t                  median;
        val_t                  newest;
    } stats_t;

    // One pending sample; drain makes the sender wait until nothing is in flight.
    typedef struct {
        val_t value;
        bit   drain;
    } sample_item_t;

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    sample_item_t sample_q[$];
    stats_t       expected_stats[int];   // keyed by transaction number
    int           sent_cnt     = 0;
    int           recv_cnt     = 0;
    int           fail_cnt     = 0;
    int           directed_n   = 0;
    int           gap_left     = 0;
    int           stall_left   = 0;
    int           quiet_cycles = 0;

    // Shadow of the window: arrival order and ascending order.
    val_t         ring_copy[WINDOW];
    val_t         sorted_copy[WINDOW];
    int unsigned  window_n    = 0;
    int unsigned  newest_slot = 0;
    logic [31:0]  frame_cnt   = '0;

    sliding_window_percentile_monitor u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Updates the shadow window with one sample and returns the statistics.
    function automatic stats_t predict_stats(val_t sample);
        stats_t      r;
        int unsigned slot;
        int unsigned n;
        int unsigned p99_idx;
        int          pos;
        int          hit;
        slot = (window_n == 0) ? 0 : (newest_slot + 1) % WINDOW;
        if (window_n >= WINDOW)
        begin
            // full: drop one sorted copy of the oldest sample, which sits in slot
            hit = -1;
            for (int i = 0; i < int'(window_n); i++)
            begin
                if (hit < 0 && sorted_copy[i] == ring_copy[slot])
                    hit = i;
            end
            if (hit >= 0)
            begin
                for (int j = hit; j + 1 < int'(window_n); j++)
                    sorted_copy[j] = sorted_copy[j + 1];
            end
            window_n = WINDOW - 1;
        end
        ring_copy[slot] = sample;
        newest_slot     = slot;
        // equal entries stay ahead of the new sample
        pos = window_n;
        while (pos > 0 && sorted_copy[pos - 1] > sample)
        begin
            sorted_copy[pos] = sorted_copy[pos - 1];
            pos--;
        end
        sorted_copy[pos] = sample;
        window_n++;
        frame_cnt++;
        n       = window_n;
        p99_idx = (n * 99) / 100;
        if (p99_idx >= n)
            p99_idx = n - 1;
        r.newest  = sample;
        r.median  = sorted_copy[n / 2];
        r.p99     = sorted_copy[p99_idx];
        r.maximum = sorted_copy[n - 1];
        r.fill    = OUT_FILL_W'(n);
        r.frames  = frame_cnt;
        return r;
    endfunction

    // Idling phases cycle over the random part: none, sender, receiver, both.
    function automatic int idle_phase(int cnt);
        if (cnt < directed_n)
            return 0;
        return ((cnt - directed_n) / PHASE_ITEMS) % 4;
    endfunction

    function automatic int sender_idle_pct(int cnt);
        case (idle_phase(cnt))
            1:       return 69;
            3:       return 11;
            default: return 0;
        endcase
    endfunction

    function automatic int receiver_stall_pct(int cnt);
        case (idle_phase(cnt))
            2:       return 69;
            3:       return 11;
            default: return 0;
        endcase
    endfunction

    // Mix of full-range values, heavy duplicates, extremes and typical frame times.
    function automatic val_t random_sample();
        val_t v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = val_t'({$urandom, $urandom});
            4, 5, 6:    v = val_t'($urandom_range(0, 15));
            7:
            begin
                case ($urandom_range(0, 3))
                    0:       v = '0;
                    1:       v = val_t'(1);
                    2:       v = VAL_MAX - 1;
                    default: v = VAL_MAX;
                endcase
            end
            default:    v = val_t'(16_664_666 + $urandom_range(0, 4000));
        endcase
        return v;
    endfunction

    task automatic add_sample(val_t value, bit drain);
        sample_item_t item;
        item.value = value;
        item.drain = drain;
        sample_q.push_back(item);
    endtask

    task automatic check_field(string field, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            fail_cnt++;
            if (fail_cnt <= 10)
                $display("result %0d: %s expected 0x%0h, got 0x%0h",
                         recv_cnt, field, want, got);
        end
    endtask

    // Driver: presents queued samples, predicts each accepted transaction.
    always @(posedge clk or negedge rst_n)
    begin : drive_samples
        bit fired;
        int outstanding;
        int idle_pct;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            sent_cnt <= 0;
            gap_left <= 0;
        end
        else
        begin
            fired    = s_tvalid && s_tready;
            idle_pct = sender_idle_pct(sent_cnt);
            if (fired)
            begin
                expected_stats[sent_cnt] = predict_stats(s_tdata[VAL_W-1:0]);
                sent_cnt <= sent_cnt + 1;
            end
            if (!s_tvalid || fired)
            begin
                // results still owed after this edge
                outstanding = sent_cnt + int'(fired) - recv_cnt - int'(m_tvalid && m_tready);
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    s_tvalid <= 1'b0;
                end
                else if (sample_q.size() == 0 || (sample_q[0].drain && outstanding != 0))
                begin
                    s_tvalid <= 1'b0;
                end
                else if ($urandom_range(0, 99) < idle_pct)
                begin
                    // mostly short gaps, sometimes one that lands deep in the busy period
                    s_tvalid <= 1'b0;
                    gap_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(16, LONG_HOLD)
                                                            : $urandom_range(0, 3);
                end
                else
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= sample_q[0].value;
                    void'(sample_q.pop_front());
                end
            end
        end
    end

    // Monitor: drives m_tready and checks each result transaction in order.
    always @(posedge clk or negedge rst_n)
    begin : check_results
        stats_t got;
        stats_t want;
        int     stall_pct;
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            recv_cnt   <= 0;
            stall_left <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = stats_t'(m_tdata);
                if (recv_cnt < sent_cnt)
                begin
                    want = expected_stats[recv_cnt];
                    expected_stats.delete(recv_cnt);
                    check_field("newest_value", 64'(want.newest),  64'(got.newest));
                    check_field("median_value", 64'(want.median),  64'(got.median));
                    check_field("p99_value",    64'(want.p99),     64'(got.p99));
                    check_field("max_value",    64'(want.maximum), 64'(got.maximum));
                    check_field("window_fill",  64'(want.fill),    64'(got.fill));
                    check_field("frames_seen",  64'(want.frames),  64'(got.frames));
                    recv_cnt <= recv_cnt + 1;
                end
                else
                begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                        $display("unexpected result transaction: 0x%0h", m_tdata);
                end
            end
            stall_pct = receiver_stall_pct(sent_cnt);
            if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                m_tready   <= 1'b0;
            end
            else if ($urandom_range(0, 99) < stall_pct)
            begin
                m_tready   <= 1'b0;
                stall_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(16, LONG_HOLD)
                                                          : $urandom_range(0, 3);
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog: no transaction on either side for too long ends the run.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("sliding_window_percentile_monitor_test NOT OK");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        // Directed part: first sample after reset, extremes, bit patterns,
        // duplicates, rising and falling runs at small fill counts.
        add_sample('0, 1'b0);
        add_sample(VAL_MAX, 1'b0);
        add_sample(VAL_MAX, 1'b0);
        add_sample('0, 1'b0);
        add_sample(val_t'(1), 1'b0);
        add_sample(VAL_MAX - 1, 1'b0);
        add_sample(40'hAA_AAAA_AAAA, 1'b0);
        add_sample(40'h55_5555_5555, 1'b0);
        add_sample(40'h80_0000_0000, 1'b0);
        add_sample(40'h00_FFFF_FFFF, 1'b0);
        add_sample(val_t'(7), 1'b0);
        add_sample(val_t'(7), 1'b0);
        add_sample(val_t'(7), 1'b0);
        add_sample(val_t'(3), 1'b0);
        add_sample(val_t'(9), 1'b0);
        add_sample(val_t'(5), 1'b0);
        add_sample(val_t'(5), 1'b0);
        add_sample(val_t'(16_666_666), 1'b0);
        add_sample(val_t'(33_333_333), 1'b0);
        for (int i = 0; i < 5; i++)
            add_sample(val_t'(1000 - i), 1'b0);
        directed_n = sample_q.size();

        // Random part; the window fills after WINDOW items and then rolls,
        // with a full drain at the start and at regular points.
        for (int i = 0; i < RANDOM_ITEMS; i++)
            add_sample(random_sample(), (i % DRAIN_EVERY) == 0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(posedge clk);
        while (sample_q.size() != 0 || s_tvalid || recv_cnt != sent_cnt);
        repeat (WINDOW + 16) @(posedge clk);

        if (fail_cnt == 0 && recv_cnt == sent_cnt)
            $display("sliding_window_percentile_monitor_test OK");
        else
            $display("sliding_window_percentile_monitor_test NOT OK");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/swpm_pkg.sv
hdl/swpm_ram.sv
hdl/swpm_cell.sv
hdl/sliding_window_percentile_monitor.sv
dv/sliding_window_percentile_monitor_test.sv
